FILE: rtl/csched_pkg.sv
// Shared types, constants and helpers for the counter priority scheduler.
`default_nettype none

package csched_pkg;

   // Table geometry and counter width
   localparam int NUM_SLOTS    = 64;
   localparam int IDLE_SLOT    = 0;
   localparam int COUNTER_BITS = 8;

   localparam int SLOT_BITS    = $clog2(NUM_SLOTS);
   localparam int IDLE_IDX     = IDLE_SLOT % NUM_SLOTS;
   localparam int WCNT_BITS    = $clog2(NUM_SLOTS + 1);
   localparam logic [63:0] CNT_MAX = (64'd1 << COUNTER_BITS) - 64'd1;

   // Fixed field widths on the ports
   localparam int FUNC_BITS    = 3;
   localparam int SLOT_FBITS   = 6;
   localparam int PRIO_BITS    = 8;
   localparam int CHAN_BITS    = 32;
   localparam int PID_BITS     = 32;
   localparam int WOKEN_BITS   = 7;
   localparam int REQ_DATA_BITS = 48;
   localparam int RSP_DATA_BITS = 48;

   // Item kinds carried in req_tuser
   localparam logic [FUNC_BITS-1:0] FUNC_ALLOC = 3'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_MKRUN = 3'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_SLEEP = 3'd2;
   localparam logic [FUNC_BITS-1:0] FUNC_WAKE  = 3'd3;
   localparam logic [FUNC_BITS-1:0] FUNC_SCHED = 3'd4;

   typedef enum logic [1:0] {
      SLOT_UNUSED   = 2'd0,
      SLOT_EMBRYO   = 2'd1,
      SLOT_SLEEPING = 2'd2,
      SLOT_RUNNABLE = 2'd3
   } slot_state_type;

   typedef logic [COUNTER_BITS-1:0] counter_type;
   typedef logic [SLOT_BITS-1:0]    slot_idx_type;

   // One process table entry as stored in the table RAM
   typedef struct packed {
      logic [CHAN_BITS-1:0] channel;
      logic [PRIO_BITS-1:0] priority_val;
      counter_type          counter;
      slot_state_type       state;
   } slot_entry_type;

   localparam int ENTRY_BITS = $bits(slot_entry_type);

   // What a table sweep does with each entry
   typedef enum logic [2:0] {
      SW_ALLOC  = 3'd0,
      SW_MKRUN  = 3'd1,
      SW_SLEEP  = 3'd2,
      SW_WAKE   = 3'd3,
      SW_PASS   = 3'd4,
      SW_REFILL = 3'd5
   } sweep_mode_type;

   typedef enum logic [2:0] {
      CS_IDLE   = 3'd0,
      CS_DECODE = 3'd1,
      CS_SWEEP  = 3'd2,
      CS_PASS1  = 3'd3,
      CS_CHECK  = 3'd4,
      CS_REFILL = 3'd5,
      CS_PASS2  = 3'd6,
      CS_COMMIT = 3'd7
   } csched_state_type;

   // Controller to datapath
   typedef struct packed {
      logic           ready;
      logic           load;
      logic           start;
      sweep_mode_type mode;
      logic           commit;
   } csched_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [FUNC_BITS-1:0] func;
      logic                 slot_in_range;
      logic                 sweep_done;
      logic                 need_refill;
      logic                 out_free;
   } csched_status_type;

   // Priority clipped to the counter range
   function automatic counter_type sat_counter(input logic [PRIO_BITS-1:0] prio);
      logic [63:0] wide;
      wide = 64'(prio);
      if (wide > CNT_MAX) begin
         wide = CNT_MAX;
      end
      return counter_type'(wide);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/csched_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module csched_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/csched_ctrl.sv
// Controller state machine: sequences decode, table sweeps and result commit.
`default_nettype none

module csched_ctrl
   import csched_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   input  wire csched_status_type status,
   output csched_cmd_type         cmd
);

   csched_state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CS_IDLE: begin
            if (req_tvalid) state_in = CS_DECODE;
         end
         CS_DECODE: begin
            unique case (status.func)
               FUNC_ALLOC, FUNC_SLEEP, FUNC_WAKE: state_in = CS_SWEEP;
               FUNC_MKRUN: state_in = status.slot_in_range ? CS_SWEEP : CS_COMMIT;
               FUNC_SCHED: state_in = CS_PASS1;
               default:    state_in = CS_COMMIT;
            endcase
         end
         CS_SWEEP: begin
            if (status.sweep_done) state_in = CS_COMMIT;
         end
         CS_PASS1: begin
            if (status.sweep_done) state_in = CS_CHECK;
         end
         CS_CHECK: begin
            state_in = status.need_refill ? CS_REFILL : CS_COMMIT;
         end
         CS_REFILL: begin
            if (status.sweep_done) state_in = CS_PASS2;
         end
         CS_PASS2: begin
            if (status.sweep_done) state_in = CS_COMMIT;
         end
         CS_COMMIT: begin
            if (status.out_free) state_in = CS_IDLE;
         end
         default: state_in = CS_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      cmd        = '0;
      cmd.mode   = SW_ALLOC;
      unique case (state_ff)
         CS_IDLE: begin
            // no beat is taken while reset is held
            cmd.ready = !reset;
            cmd.load  = req_tvalid && !reset;
         end
         CS_DECODE: begin
            unique case (status.func)
               FUNC_ALLOC: begin
                  cmd.start = 1'b1;
                  cmd.mode  = SW_ALLOC;
               end
               FUNC_MKRUN: begin
                  cmd.start = status.slot_in_range;
                  cmd.mode  = SW_MKRUN;
               end
               FUNC_SLEEP: begin
                  cmd.start = 1'b1;
                  cmd.mode  = SW_SLEEP;
               end
               FUNC_WAKE: begin
                  cmd.start = 1'b1;
                  cmd.mode  = SW_WAKE;
               end
               FUNC_SCHED: begin
                  cmd.start = 1'b1;
                  cmd.mode  = SW_PASS;
               end
               default: cmd.start = 1'b0;
            endcase
         end
         CS_CHECK: begin
            cmd.start = status.need_refill;
            cmd.mode  = SW_REFILL;
         end
         CS_REFILL: begin
            // second pass starts right behind the refill sweep
            cmd.start = status.sweep_done;
            cmd.mode  = SW_PASS;
         end
         CS_COMMIT: begin
            cmd.commit = status.out_free;
         end
         default: cmd.start = 1'b0;
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/csched_dpath.sv
// Datapath: item registers, table RAM with sweep engine, accumulators, result register.
`default_nettype none

module csched_dpath
   import csched_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire csched_cmd_type           cmd,
   output csched_status_type             status,
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,
   input  wire logic [FUNC_BITS-1:0]     req_tuser,
   input  wire logic                     rsp_tready,
   output logic                          rsp_tvalid,
   output logic      [RSP_DATA_BITS-1:0] rsp_tdata
);

   // Latched item
   logic [FUNC_BITS-1:0]  func_ff;
   logic [SLOT_FBITS-1:0] slot_ff;
   logic [PRIO_BITS-1:0]  prio_ff;
   logic [CHAN_BITS-1:0]  chan_ff;
   logic                  mem_ok_ff;

   // Sweep engine
   sweep_mode_type        mode_ff;
   slot_idx_type          rd_addr_ff, rd_addr_in;
   logic [SLOT_BITS:0]    issue_left_ff, issue_left_in;
   logic                  rd_vld_ff;
   slot_idx_type          rd_idx_ff;
   logic [NUM_SLOTS-1:0]  valid_ff;

   // Accumulators
   logic                  found_ff;
   slot_idx_type          found_idx_ff;
   slot_entry_type        found_entry_ff;
   slot_idx_type          best_ff;
   counter_type           top_ff;
   logic                  others_ff;
   logic [WCNT_BITS-1:0]  woken_ff;

   // Scheduler state
   slot_idx_type          current_ff;
   logic [PID_BITS-1:0]   pid_ff;

   // Result register
   logic                     rsp_valid_ff;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   // RAM ports
   logic                  wr_en;
   slot_idx_type          wr_addr;
   slot_entry_type        wr_data;
   logic [ENTRY_BITS-1:0] ram_q;
   slot_entry_type        entry;
   logic                  rd_en;
   logic                  single;
   slot_idx_type          start_addr;
   logic                  alloc_hit;

   // Item capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff   <= req_tuser;
         slot_ff   <= req_tdata[5:0];
         prio_ff   <= req_tdata[13:6];
         chan_ff   <= req_tdata[45:14];
         mem_ok_ff <= req_tdata[46];
      end
   end

   // Sweep address and issue count
   always_comb begin
      single     = (cmd.mode == SW_MKRUN) || (cmd.mode == SW_SLEEP);
      start_addr = '0;
      if (cmd.mode == SW_MKRUN) begin
         start_addr = slot_idx_type'(slot_ff);
      end else if (cmd.mode == SW_SLEEP) begin
         start_addr = current_ff;
      end
      rd_en         = (issue_left_ff != '0);
      rd_addr_in    = rd_addr_ff;
      issue_left_in = issue_left_ff;
      if (cmd.start) begin
         rd_addr_in    = start_addr;
         issue_left_in = single ? (SLOT_BITS+1)'(1) : (SLOT_BITS+1)'(NUM_SLOTS);
      end else if (rd_en) begin
         rd_addr_in    = rd_addr_ff + 1'b1;
         issue_left_in = issue_left_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_left_ff <= '0;
         rd_vld_ff     <= 1'b0;
      end else begin
         issue_left_ff <= issue_left_in;
         rd_vld_ff     <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff <= rd_addr_in;
      rd_idx_ff  <= rd_addr_ff;
      if (cmd.start) begin
         mode_ff <= cmd.mode;
      end
   end

   csched_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (NUM_SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_ff),
      .rd_data (ram_q)
   );

   // Entries never written read as the reset value
   assign entry     = valid_ff[rd_idx_ff] ? slot_entry_type'(ram_q) : '0;
   assign alloc_hit = found_ff && mem_ok_ff;

   // Write back of the entry under the sweep, or the allocate commit
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = rd_idx_ff;
      wr_data = entry;
      if (rd_vld_ff) begin
         unique case (mode_ff)
            SW_MKRUN: begin
               wr_en                = 1'b1;
               wr_data.state        = SLOT_RUNNABLE;
               wr_data.priority_val = prio_ff;
               wr_data.counter      = sat_counter(prio_ff);
            end
            SW_SLEEP: begin
               wr_en           = 1'b1;
               wr_data.state   = SLOT_SLEEPING;
               wr_data.channel = chan_ff;
            end
            SW_WAKE: begin
               wr_en           = (entry.state == SLOT_SLEEPING) && (entry.channel == chan_ff);
               wr_data.state   = SLOT_RUNNABLE;
               wr_data.channel = '0;
            end
            SW_REFILL: begin
               wr_en           = 1'b1;
               wr_data.counter = sat_counter(entry.priority_val);
            end
            default: wr_en = 1'b0;
         endcase
      end else if (cmd.commit && (func_ff == FUNC_ALLOC) && alloc_hit) begin
         wr_en         = 1'b1;
         wr_addr       = found_idx_ff;
         wr_data       = found_entry_ff;
         wr_data.state = SLOT_EMBRYO;
      end
   end

   // Written entries become valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // Per-sweep accumulators
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         found_ff  <= 1'b0;
         best_ff   <= slot_idx_type'(IDLE_IDX);
         top_ff    <= '0;
         others_ff <= 1'b0;
         woken_ff  <= '0;
      end else if (rd_vld_ff) begin
         unique case (mode_ff)
            SW_ALLOC: begin
               if (!found_ff && (entry.state == SLOT_UNUSED)) begin
                  found_ff       <= 1'b1;
                  found_idx_ff   <= rd_idx_ff;
                  found_entry_ff <= entry;
               end
            end
            SW_WAKE: begin
               if (wr_en) woken_ff <= woken_ff + 1'b1;
            end
            SW_PASS: begin
               if (entry.state == SLOT_RUNNABLE) begin
                  if (rd_idx_ff != slot_idx_type'(IDLE_IDX)) others_ff <= 1'b1;
                  // strict compare keeps the first slot on a tie
                  if (entry.counter > top_ff) begin
                     top_ff  <= entry.counter;
                     best_ff <= rd_idx_ff;
                  end
               end
            end
            default: found_ff <= found_ff;
         endcase
      end
   end

   // Current slot and pid counter
   always_ff @(posedge clock) begin
      if (reset) begin
         current_ff <= slot_idx_type'(IDLE_IDX);
         pid_ff     <= '0;
      end else if (cmd.commit) begin
         if (func_ff == FUNC_SCHED) current_ff <= best_ff;
         // pid is consumed even when the stack allocation failed
         if ((func_ff == FUNC_ALLOC) && found_ff) pid_ff <= pid_ff + 1'b1;
      end
   end

   // Result beat
   always_comb begin
      rsp_data_in = '0;
      unique case (func_ff)
         FUNC_ALLOC: begin
            if (alloc_hit) begin
               rsp_data_in[0]    = 1'b1;
               rsp_data_in[6:1]  = SLOT_FBITS'(found_idx_ff);
               rsp_data_in[38:7] = pid_ff;
            end
         end
         FUNC_WAKE: begin
            rsp_data_in[45:39] = WOKEN_BITS'(woken_ff);
         end
         FUNC_SCHED: begin
            rsp_data_in[0]   = 1'b1;
            rsp_data_in[6:1] = SLOT_FBITS'(best_ff);
         end
         default: rsp_data_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Status to the controller
   always_comb begin
      status.func          = func_ff;
      status.slot_in_range = (32'(slot_ff) < 32'(NUM_SLOTS));
      status.sweep_done    = rd_vld_ff && (issue_left_ff == '0);
      status.need_refill   = (best_ff == slot_idx_type'(IDLE_IDX)) && others_ff;
      status.out_free      = !rsp_valid_ff || rsp_tready;
   end

endmodule

`default_nettype wire

FILE: rtl/counter_priority_scheduler_unit.sv
// Make runnable and sleep sweep one slot, allocate and wake the table; schedule sweeps it
// once, or with a counter refill refills every counter and sweeps again. Unused codes go
// straight to commit. One item at a time; the next beat can be taken in the cycle after
// the result is loaded. Each table sweep reads one slot per cycle from the table RAM; a
// result beat waits in an output register while the next item is taken. Reset (sync,
// active high) clears per-slot valid bits, so every slot reads unused; idle current, pid 0.
`default_nettype none

module counter_priority_scheduler_unit
   import csched_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   // req_tdata: slot[5:0], priority_req[13:6], channel[45:14], mem_ok[46], zero fill
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,
   // req_tuser: func[2:0]
   input  wire logic [FUNC_BITS-1:0]     req_tuser,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // rsp_tdata: ok[0], chosen_slot[6:1], new_pid[38:7], woken_count[45:39], zero fill
   output logic      [RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready
);

   csched_cmd_type    cmd;
   csched_status_type status;

   csched_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .status     (status),
      .cmd        (cmd)
   );

   csched_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

   assign req_tready = cmd.ready;

   // One item in flight: no new beat right after one is taken
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input beat taken while an item is in flight");

   // A commit always presents a result beat
   a_commit_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_tvalid)
      else $error("commit without a result beat");

   // Sweeps only run while an item is in flight
   a_sweep_busy: assert property (@(posedge clock) disable iff (reset)
      status.sweep_done |-> !cmd.ready)
      else $error("table sweep active while idle");

   // Commit never overwrites a result that is not being taken
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_tvalid || rsp_tready))
      else $error("result register overrun");

endmodule

`default_nettype wire

FILE: tb/csched_checker.sv
// Checker for the scheduler: keeps its own copy of the process table and compares each result beat.
`timescale 1ns / 100ps

module csched_checker
   import csched_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,
   input  wire logic [FUNC_BITS-1:0]     req_tuser,
   input  wire logic                     req_tvalid,
   input  wire logic                     req_tready,
   input  wire logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input  wire logic                     rsp_tvalid,
   input  wire logic                     rsp_tready,
   output int                            fail_count,
   output int                            pending_count,
   output int                            result_count
);

   // Field positions in the request and result beats
   localparam int REQ_PRIO_LSB  = SLOT_FBITS;
   localparam int REQ_CHAN_LSB  = REQ_PRIO_LSB + PRIO_BITS;
   localparam int REQ_MEM_BIT   = REQ_CHAN_LSB + CHAN_BITS;
   localparam int RSP_SLOT_LSB  = 1;
   localparam int RSP_PID_LSB   = RSP_SLOT_LSB + SLOT_FBITS;
   localparam int RSP_WOKEN_LSB = RSP_PID_LSB + PID_BITS;

   typedef struct packed {
      logic                  ok;
      logic [SLOT_FBITS-1:0] chosen_slot;
      logic [PID_BITS-1:0]   new_pid;
      logic [WOKEN_BITS-1:0] woken_count;
   } sched_result_type;

   // Mirror of the process table
   slot_state_type       tbl_state [NUM_SLOTS];
   counter_type          tbl_count [NUM_SLOTS];
   logic [PRIO_BITS-1:0] tbl_prio  [NUM_SLOTS];
   logic [CHAN_BITS-1:0] tbl_chan  [NUM_SLOTS];
   int unsigned          cur_slot;
   logic [PID_BITS-1:0]  pid_next;
   sched_result_type     awaited_results [$];

   function automatic counter_type clip_to_counter(input logic [PRIO_BITS-1:0] prio);
      return (64'(prio) > CNT_MAX) ? counter_type'(CNT_MAX) : counter_type'(prio);
   endfunction

   // Runnable slot with the largest positive counter, lowest index on a tie, else idle
   function automatic int unsigned best_runnable(output bit others_ready);
      int unsigned best;
      counter_type top_count;
      best = IDLE_IDX;
      top_count = '0;
      others_ready = 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (tbl_state[i] == SLOT_RUNNABLE) begin
            if (i != IDLE_IDX) begin
               others_ready = 1'b1;
            end
            if (tbl_count[i] > top_count) begin
               top_count = tbl_count[i];
               best = i;
            end
         end
      end
      return best;
   endfunction

   // Applies one request beat to the mirror and returns the result it should produce
   function automatic sched_result_type apply_item(input logic [FUNC_BITS-1:0]     func,
                                                   input logic [REQ_DATA_BITS-1:0] data);
      sched_result_type      res;
      logic [SLOT_FBITS-1:0] slot_f;
      logic [PRIO_BITS-1:0]  prio_f;
      logic [CHAN_BITS-1:0]  chan_f;
      logic                  mem_f;
      int unsigned           free_idx;
      int unsigned           pick;
      int unsigned           sleeper;
      bit                    others_ready;
      res = '0;
      slot_f = data[SLOT_FBITS-1:0];
      prio_f = data[REQ_PRIO_LSB +: PRIO_BITS];
      chan_f = data[REQ_CHAN_LSB +: CHAN_BITS];
      mem_f  = data[REQ_MEM_BIT];
      case (func)
         FUNC_ALLOC: begin
            free_idx = NUM_SLOTS;
            for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
               if (tbl_state[i] == SLOT_UNUSED) free_idx = i;
            end
            // pid is used up even when the stack allocation fails
            if (free_idx < NUM_SLOTS) begin
               if (mem_f) begin
                  tbl_state[free_idx] = SLOT_EMBRYO;
                  res.ok = 1'b1;
                  res.chosen_slot = SLOT_FBITS'(free_idx);
                  res.new_pid = pid_next;
               end
               pid_next = pid_next + 1'b1;
            end
         end
         FUNC_MKRUN: begin
            if (int'(slot_f) < NUM_SLOTS) begin
               tbl_state[slot_f] = SLOT_RUNNABLE;
               tbl_prio[slot_f] = prio_f;
               tbl_count[slot_f] = clip_to_counter(prio_f);
            end
         end
         FUNC_SLEEP: begin
            sleeper = cur_slot % NUM_SLOTS;
            tbl_chan[sleeper] = chan_f;
            tbl_state[sleeper] = SLOT_SLEEPING;
         end
         FUNC_WAKE: begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (tbl_state[i] == SLOT_SLEEPING && tbl_chan[i] == chan_f) begin
                  tbl_state[i] = SLOT_RUNNABLE;
                  tbl_chan[i] = '0;
                  res.woken_count = res.woken_count + 1'b1;
               end
            end
         end
         FUNC_SCHED: begin
            pick = best_runnable(others_ready);
            // one refill from priorities, then a single extra pass
            if (pick == IDLE_IDX && others_ready) begin
               for (int i = 0; i < NUM_SLOTS; i++) begin
                  tbl_count[i] = clip_to_counter(tbl_prio[i]);
               end
               pick = best_runnable(others_ready);
            end
            cur_slot = pick;
            res.ok = 1'b1;
            res.chosen_slot = SLOT_FBITS'(pick);
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   task automatic compare_beat(input logic [RSP_DATA_BITS-1:0] data);
      sched_result_type want;
      if (awaited_results.size() == 0) begin
         $error("result beat 0x%h arrived with nothing outstanding", data);
         fail_count++;
      end else begin
         want = awaited_results.pop_front();
         result_count++;
         if (data[0] !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, data[0]);
            fail_count++;
         end
         if (data[RSP_SLOT_LSB +: SLOT_FBITS] !== want.chosen_slot) begin
            $error("chosen_slot: expected %0d, got %0d", want.chosen_slot,
                   data[RSP_SLOT_LSB +: SLOT_FBITS]);
            fail_count++;
         end
         if (data[RSP_PID_LSB +: PID_BITS] !== want.new_pid) begin
            $error("new_pid: expected %0d, got %0d", want.new_pid,
                   data[RSP_PID_LSB +: PID_BITS]);
            fail_count++;
         end
         if (data[RSP_WOKEN_LSB +: WOKEN_BITS] !== want.woken_count) begin
            $error("woken_count: expected %0d, got %0d", want.woken_count,
                   data[RSP_WOKEN_LSB +: WOKEN_BITS]);
            fail_count++;
         end
      end
   endtask

   // Check the outgoing beat before predicting, so a result never pairs with its own request
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            tbl_state[i] = SLOT_UNUSED;
            tbl_count[i] = '0;
            tbl_prio[i] = '0;
            tbl_chan[i] = '0;
         end
         cur_slot = IDLE_IDX;
         pid_next = '0;
         awaited_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            compare_beat(rsp_tdata);
         end
         if (req_tvalid && req_tready) begin
            awaited_results.push_back(apply_item(req_tuser, req_tdata));
         end
      end
      pending_count = awaited_results.size();
   end

endmodule

FILE: tb/tb_counter_priority_scheduler_unit.sv
// Testbench top for the scheduler: clock, reset, request and backpressure stimulus, verdict.
`timescale 1ns / 100ps

module tb_counter_priority_scheduler_unit
   import csched_pkg::*;
();

   localparam logic [FUNC_BITS-1:0] FUNC_SPARE_LO  = 3'd5;
   localparam logic [FUNC_BITS-1:0] FUNC_SPARE_MID = 3'd6;
   localparam logic [FUNC_BITS-1:0] FUNC_SPARE_HI  = 3'd7;
   localparam int RANDOM_ITEMS  = 650;
   localparam int DRAIN_LIMIT   = 50000;
   localparam int SETTLE_CYCLES = 3 * NUM_SLOTS + 60;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic [FUNC_BITS-1:0]     req_tuser  = '0;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b1;

   bit                   quiet      = 1'b0;
   int                   stall_left = 0;
   int                   func_seen [8];
   logic [CHAN_BITS-1:0] chan_pool [4];
   int                   chk_fail;
   int                   chk_pending;
   int                   chk_results;

   always #4 clock = ~clock;

   counter_priority_scheduler_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   csched_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .fail_count    (chk_fail),
      .pending_count (chk_pending),
      .result_count  (chk_results)
   );

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // Favor a few values so that counter ties are common
   function automatic logic [PRIO_BITS-1:0] pick_prio();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return 8'd128;
         default: return PRIO_BITS'($urandom_range(0, 255));
      endcase
   endfunction

   // Mostly pooled channels so that wakes find sleepers
   function automatic logic [CHAN_BITS-1:0] pick_chan();
      if ($urandom_range(0, 99) < 85) return chan_pool[$urandom_range(0, 3)];
      return $urandom();
   endfunction

   // One request beat; valid stays up into the next beat when no gap follows
   task automatic send_beat(input logic [FUNC_BITS-1:0]  func,
                            input logic [SLOT_FBITS-1:0] slot,
                            input logic [PRIO_BITS-1:0]  prio,
                            input logic [CHAN_BITS-1:0]  chan,
                            input logic                  mem_ok);
      int gap;
      @(negedge clock);
      req_tuser  <= func;
      req_tdata  <= {1'b0, mem_ok, chan, prio, slot};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      func_seen[func]++;
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Result side backpressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!quiet && !reset && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
   end

   initial begin
      #10_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      int sent;
      int r;
      int drain;
      int leftover;
      chan_pool[0] = '0;
      chan_pool[1] = '1;
      chan_pool[2] = $urandom();
      chan_pool[3] = $urandom();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Sleep and wake on the idle slot while it is still unused
      send_beat(FUNC_SLEEP, '0, '0, 32'hA5A5_A5A5, 1'b0);
      send_beat(FUNC_WAKE,  '0, '0, 32'hA5A5_A5A5, 1'b0);
      // Only the idle slot runnable, at a zero counter
      send_beat(FUNC_SCHED, '0, '0, '0, 1'b0);
      // Allocation, a failed stack allocation, allocation again
      send_beat(FUNC_ALLOC, '0, '0, '0, 1'b1);
      send_beat(FUNC_ALLOC, '1, '1, '1, 1'b0);
      send_beat(FUNC_ALLOC, '0, '0, '0, 1'b1);
      // Spare function codes
      send_beat(FUNC_SPARE_LO, '1, '1, '1, 1'b1);
      send_beat(FUNC_SPARE_MID, '1, '1, '1, 1'b1);
      send_beat(FUNC_SPARE_HI, '1, '1, '1, 1'b1);
      // Tie at the top counter: lower slot wins
      send_beat(FUNC_MKRUN, 6'd63, 8'd255, '0, 1'b0);
      send_beat(FUNC_MKRUN, 6'd5,  8'd255, '1, 1'b1);
      send_beat(FUNC_SCHED, '0, '0, '0, 1'b0);
      send_beat(FUNC_SLEEP, '0, '0, '1, 1'b0);
      send_beat(FUNC_SCHED, '0, '0, '0, 1'b0);
      send_beat(FUNC_SLEEP, '0, '0, '1, 1'b0);
      // Wake with no match, then both sleepers at once
      send_beat(FUNC_WAKE, '0, '0, '0, 1'b0);
      send_beat(FUNC_WAKE, '0, '0, '1, 1'b0);
      // All counters zero with others runnable: refill pass, idle fallback
      send_beat(FUNC_MKRUN, 6'd5,  8'd0, '0, 1'b0);
      send_beat(FUNC_MKRUN, 6'd63, 8'd0, '0, 1'b0);
      send_beat(FUNC_SCHED, '0, '0, '0, 1'b0);
      // Idle slot wins on its own counter
      send_beat(FUNC_MKRUN, 6'd0, 8'd200, '0, 1'b0);
      send_beat(FUNC_MKRUN, 6'd9, 8'd100, '0, 1'b0);
      send_beat(FUNC_SCHED, '0, '0, '0, 1'b0);
      // Sleep and wake on channel zero
      send_beat(FUNC_SLEEP, '0, '0, '0, 1'b0);
      send_beat(FUNC_WAKE,  '0, '0, '0, 1'b0);

      // Random traffic; spare codes do not count toward the item total
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         quiet = (sent >= 250 && sent < 350);
         r = $urandom_range(0, 99);
         if (r < 12) begin
            send_beat(FUNC_ALLOC, SLOT_FBITS'($urandom()), pick_prio(), $urandom(),
                      $urandom_range(0, 3) != 0);
            sent++;
         end else if (r < 37) begin
            send_beat(FUNC_MKRUN, SLOT_FBITS'($urandom_range(0, NUM_SLOTS - 1)), pick_prio(),
                      $urandom(), 1'($urandom()));
            sent++;
         end else if (r < 50) begin
            send_beat(FUNC_SLEEP, SLOT_FBITS'($urandom()), pick_prio(), pick_chan(),
                      1'($urandom()));
            sent++;
         end else if (r < 63) begin
            send_beat(FUNC_WAKE, SLOT_FBITS'($urandom()), pick_prio(), pick_chan(),
                      1'($urandom()));
            sent++;
         end else if (r < 83) begin
            send_beat(FUNC_SCHED, SLOT_FBITS'($urandom()), pick_prio(), $urandom(),
                      1'($urandom()));
            sent++;
         end else if (r < 95) begin
            // park whatever was just picked
            send_beat(FUNC_SCHED, '0, '0, '0, 1'b0);
            send_beat(FUNC_SLEEP, '0, '0, pick_chan(), 1'b0);
            sent += 2;
         end else begin
            send_beat(FUNC_BITS'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI)),
                      SLOT_FBITS'($urandom()), pick_prio(), $urandom(), 1'($urandom()));
         end
      end
      quiet = 1'b0;
      @(negedge clock);
      req_tvalid <= 1'b0;

      // Drain, then give a stray extra beat time to show up
      drain = 0;
      while (chk_pending != 0 && drain < DRAIN_LIMIT) begin
         @(negedge clock);
         drain++;
      end
      leftover = chk_pending;
      if (leftover != 0) begin
         $error("%0d expected results never arrived", leftover);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("sent %0d allocate, %0d make-runnable, %0d sleep, %0d wake, %0d schedule, %0d spare",
               func_seen[FUNC_ALLOC], func_seen[FUNC_MKRUN], func_seen[FUNC_SLEEP],
               func_seen[FUNC_WAKE], func_seen[FUNC_SCHED],
               func_seen[FUNC_SPARE_LO] + func_seen[FUNC_SPARE_MID] + func_seen[FUNC_SPARE_HI]);
      $display("%0d result beats compared under random gaps and output stalls", chk_results);
      if (chk_fail == 0 && leftover == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
